// ===== hdl/tcr_pkg.sv =====
// shared constants and types for the 2-adic cube root block
package tcr_pkg;

    // iteration limit register
    localparam int ITER_W = 6;
    localparam logic [ITER_W-1:0] ITER_RESET = 6'd12;

    // newton refinements of the odd inverse, 3 -> 96 correct bits
    localparam int INV_STEPS = 5;
    localparam int INV_CNT_W = 3;

    // partial product phases of the shared multiplier
    localparam int PH_W = 2;
    localparam logic [PH_W-1:0] PH_LL = 2'd0;
    localparam logic [PH_W-1:0] PH_LH = 2'd1;
    localparam logic [PH_W-1:0] PH_HL = 2'd2;

    // multiplier status seen by the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } t_mul_stat;

endpackage

// ===== hdl/twoadic_cube_root.sv =====
// top level of the 2-adic cube root block: sequencer, operand registers and result register
//
// usage
//  - input channel i_valid / o_ready carries i_value; only its low WIDTH bits are used
//  - output channel o_valid / i_ready carries o_root and o_invalid_input
//  - i_cfg_wr_en / i_cfg_wr_data write the iteration limit (resets to 12); write only
//    while the block is idle
//  - one operand is worked on at a time; o_ready is high only while the sequencer idles
//  - an even operand, or an odd one at a limit of 0, skips the iteration; with the output
//    register free its result is loaded from the result stage and the sequencer idles again
//  - an odd operand runs newton steps up to the limit; a zero residual ends the search
//    within a step, after two products and the test; the result is loaded into the output
//    register once the search ends and the register is free
//  - each step uses the shared multiplier for 13 modular products, each one an issue, three
//    half-width partial products and a handoff, plus the zero residual test
//  - a finished result sits in the output register until it is transferred; the next
//    operand can be transferred in meanwhile, and its result waits if the register is full
//  - reset is synchronous, active low: the sequencer idles, the output register empties
//    and the iteration limit returns to 12
module twoadic_cube_root #(
    parameter int WIDTH = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [63:0]                 i_value,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [63:0]                 o_root,
    output logic                        o_invalid_input,
    input  logic                        i_cfg_wr_en,
    input  logic [tcr_pkg::ITER_W-1:0]  i_cfg_wr_data
);

    // sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_X2    = 4'd1;  // x * x
    localparam logic [3:0] S_X3    = 4'd2;  // x^2 * x, residual
    localparam logic [3:0] S_CHK   = 4'd3;  // zero residual test, derivative
    localparam logic [3:0] S_INV_T = 4'd4;  // t = 2 - d * y
    localparam logic [3:0] S_INV_Y = 4'd5;  // y = y * t
    localparam logic [3:0] S_G     = 4'd6;  // x -= f * y
    localparam logic [3:0] S_DONE  = 4'd7;  // hand result to output register

    logic [3:0]                       r_state;
    logic                             r_wait;
    logic [tcr_pkg::ITER_W-1:0]       r_limit;
    logic [tcr_pkg::ITER_W-1:0]       r_iter;
    logic [tcr_pkg::INV_CNT_W-1:0]    r_k;
    logic                             r_bad;
    logic [WIDTH-1:0]                 r_a;
    logic [WIDTH-1:0]                 r_x;
    logic [WIDTH-1:0]                 r_x2;
    logic [WIDTH-1:0]                 r_f;
    logic [WIDTH-1:0]                 r_d;
    logic [WIDTH-1:0]                 r_y;
    logic [WIDTH-1:0]                 r_t;
    logic                             r_out_valid;
    logic [WIDTH-1:0]                 r_root;
    logic                             r_invalid;

    logic [WIDTH-1:0]                 w_op_a;
    logic [WIDTH-1:0]                 w_op_b;
    logic                             w_mul_state;
    logic                             w_start;
    logic                             w_done;
    logic [WIDTH-1:0]                 w_prod;
    tcr_pkg::t_mul_stat               w_mul_stat;
    logic [WIDTH-1:0]                 w_deriv;
    logic                             w_in_xfer;
    logic                             w_out_load;

    assign w_in_xfer = i_valid && o_ready;
    // result register frees up on the same edge it is transferred out
    assign w_out_load = (r_state == S_DONE) && (!r_out_valid || i_ready);

    // 3 * x^2 as shift and add
    assign w_deriv = {r_x2[WIDTH-2:0], 1'b0} + r_x2;

    // operand selection for the shared multiplier
    always_comb begin
        w_mul_state = 1'b1;
        case (r_state)
            S_X2: begin
                w_op_a = r_x;
                w_op_b = r_x;
            end
            S_X3: begin
                w_op_a = r_x2;
                w_op_b = r_x;
            end
            S_INV_T: begin
                w_op_a = r_d;
                w_op_b = r_y;
            end
            S_INV_Y: begin
                w_op_a = r_y;
                w_op_b = r_t;
            end
            S_G: begin
                w_op_a = r_f;
                w_op_b = r_y;
            end
            default: begin
                w_op_a      = r_x;
                w_op_b      = r_x;
                w_mul_state = 1'b0;
            end
        endcase
    end

    // issue once per multiply state, then wait for the product
    assign w_start = w_mul_state && !r_wait;
    assign w_done  = r_wait && w_mul_stat.done;

    tcr_mul #(
        .WIDTH (WIDTH)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_a     (w_op_a),
        .i_b     (w_op_b),
        .o_prod  (w_prod),
        .o_stat  (w_mul_stat)
    );

    // sequencer and control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wait      <= 1'b0;
            r_limit     <= tcr_pkg::ITER_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_limit <= i_cfg_wr_data;
            end

            if (w_start) begin
                r_wait <= 1'b1;
            end else if (w_done) begin
                r_wait <= 1'b0;
            end

            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_in_xfer) begin
                        // even operand or zero limit skips the iteration
                        if (!i_value[0] || (r_limit == '0)) begin
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_X2;
                        end
                    end
                end
                S_X2: begin
                    if (w_done) begin
                        r_state <= S_X3;
                    end
                end
                S_X3: begin
                    if (w_done) begin
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    if (r_f == '0) begin
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_INV_T;
                    end
                end
                S_INV_T: begin
                    if (w_done) begin
                        r_state <= S_INV_Y;
                    end
                end
                S_INV_Y: begin
                    if (w_done) begin
                        if (r_k == tcr_pkg::INV_CNT_W'(tcr_pkg::INV_STEPS - 1)) begin
                            r_state <= S_G;
                        end else begin
                            r_state <= S_INV_T;
                        end
                    end
                end
                S_G: begin
                    if (w_done) begin
                        if (r_iter + 1'b1 == r_limit) begin
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_X2;
                        end
                    end
                end
                S_DONE: begin
                    if (w_out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    r_a    <= i_value[WIDTH-1:0];
                    r_iter <= '0;
                    r_bad  <= !i_value[0];
                    r_x    <= i_value[0] ? WIDTH'(1) : '0;
                end
            end
            S_X2: begin
                if (w_done) begin
                    r_x2 <= w_prod;
                end
            end
            S_X3: begin
                if (w_done) begin
                    r_f <= w_prod - r_a;
                end
            end
            S_CHK: begin
                // inverse seed: an odd d is its own inverse to 3 bits
                r_d <= w_deriv;
                r_y <= w_deriv;
                r_k <= '0;
            end
            S_INV_T: begin
                if (w_done) begin
                    r_t <= WIDTH'(2) - w_prod;
                end
            end
            S_INV_Y: begin
                if (w_done) begin
                    r_y <= w_prod;
                    r_k <= r_k + 1'b1;
                end
            end
            S_G: begin
                if (w_done) begin
                    r_x    <= r_x - w_prod;
                    r_iter <= r_iter + 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_root    <= r_x;
            r_invalid <= r_bad;
        end
    end

    assign o_ready         = (r_state == S_IDLE);
    assign o_valid         = r_out_valid;
    assign o_root          = 64'(r_root);
    assign o_invalid_input = r_invalid;

    // the multiplier is never restarted while it is still working
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start |-> !w_mul_stat.busy)
        else $error("multiplier issued while busy");

    // an invalid result always carries a zero root
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_invalid_input) |-> (o_root == '0))
        else $error("invalid result with nonzero root");

    // an even operand goes straight to the result stage flagged invalid
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_xfer && !i_value[0]) |=> ((r_state == S_DONE) && r_bad && (r_x == '0)))
        else $error("even operand not short-cut");

    // a product only arrives while the sequencer is waiting in a multiply state
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mul_stat.done |-> (r_wait && w_mul_state))
        else $error("stray multiplier product");

endmodule

// ===== hdl/tcr_mul.sv =====
// low-half modular multiplier built from one half-width multiplier, reused over its phases
module tcr_mul #(
    parameter int WIDTH = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [WIDTH-1:0]      i_a,
    input  logic [WIDTH-1:0]      i_b,
    output logic [WIDTH-1:0]      o_prod,
    output tcr_pkg::t_mul_stat    o_stat
);

    localparam int HALF = (WIDTH + 1) / 2;
    localparam int PW   = 2 * HALF;

    logic [PW-1:0]             r_a;
    logic [PW-1:0]             r_b;
    logic [PW-1:0]             r_acc;
    logic [tcr_pkg::PH_W-1:0]  r_ph;
    logic                      r_busy;
    logic                      r_done;

    logic [HALF-1:0]           w_opa;
    logic [HALF-1:0]           w_opb;
    logic [PW-1:0]             w_pp;
    logic [PW-1:0]             w_term;

    // operand halves per phase
    always_comb begin
        case (r_ph)
            tcr_pkg::PH_LL: begin
                w_opa = r_a[HALF-1:0];
                w_opb = r_b[HALF-1:0];
            end
            tcr_pkg::PH_LH: begin
                w_opa = r_a[HALF-1:0];
                w_opb = r_b[PW-1:HALF];
            end
            tcr_pkg::PH_HL: begin
                w_opa = r_a[PW-1:HALF];
                w_opb = r_b[HALF-1:0];
            end
            default: begin
                w_opa = '0;
                w_opb = '0;
            end
        endcase
    end

    assign w_pp   = PW'(w_opa) * PW'(w_opb);
    // cross terms land in the upper half, their carries fall off the top
    assign w_term = (r_ph == tcr_pkg::PH_LL) ? w_pp : (w_pp << HALF);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_ph   <= tcr_pkg::PH_LL;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_ph   <= tcr_pkg::PH_LL;
            end else if (r_busy) begin
                if (r_ph == tcr_pkg::PH_HL) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_ph <= r_ph + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_a   <= PW'(i_a);
            r_b   <= PW'(i_b);
            r_acc <= '0;
        end else if (r_busy) begin
            r_acc <= r_acc + w_term;
        end
    end

    assign o_prod      = r_acc[WIDTH-1:0];
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule
